// File: design/lld_pkg.sv
// Shared types, constants and codes for the least-loaded dispatcher.
// No dependencies.
package lld_pkg;
   localparam int MaxServers = 8;
   localparam int QueueDepth = 16;
   localparam int SrvW = $clog2(MaxServers);
   localparam int PosW = $clog2(QueueDepth);
   localparam int FillW = $clog2(QueueDepth + 1);
   localparam int ActW = $clog2(MaxServers + 1);
   localparam int AddrW = SrvW + PosW;

   localparam logic [1:0] ST_ENQ = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SERVED = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic CSR_INITIAL = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0] prio;
      logic [15:0] stamp;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic start_scan;   // clear scan registers, latch request
      logic scan_step;    // visit one server / one queue entry
      logic enq_commit;   // write new entry
      logic shift_step;   // move one entry down
      logic srv_finish;   // decrement fill of served queue
      logic rsp_load;     // capture result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_service;
      logic scan_last;
      logic shift_last;
      logic empty_or_bad;
   } sts_type;
endpackage

// File: design/lld_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface lld_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/least_loaded_priority_dispatcher_top.sv
// Least-loaded task dispatcher: one transaction in, one transaction out. An enqueue
// scans the active servers one per cycle, then decides and loads its result. A service
// scans the chosen queue one entry per cycle through the single memory read port, then
// closes the gap by moving each later entry down one per cycle; an empty queue skips
// the gap closing. Items are handled one at a time; the next transaction can be taken
// in the cycle after a result is loaded. A finished result waits in the output
// register while the next item is worked on; only a result still waiting when the
// next one is ready holds the controller.
// Depends on lld_pkg, lld_if, lld_ctrl and lld_dpath.
module least_loaded_priority_dispatcher_top import lld_pkg::*; (
   input  logic clock,
   input  logic reset,
   lld_if.sink req,
   lld_if.source rsp,
   input  logic csr_we,
   input  logic csr_addr,
   input  logic [7:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   logic rsp_full, take;
   logic [1:0] st;
   logic [2:0] sel;
   logic [15:0] oid;
   logic [7:0] opr;
   logic added, vld_ff;
   logic [29:0] out_ff;

   // Hold the result until the sink takes the transaction.
   assign take = rsp.valid && rsp.ready;

   lld_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_full(rsp_full), .sts, .cmd
   );

   lld_dpath u_dpath (
      .clock, .reset, .cmd, .sts,
      .in_func(req.data[27]), .in_id(req.data[26:11]), .in_prio(req.data[10:3]),
      .in_idx(req.data[2:0]),
      .csr_we, .csr_addr, .csr_wdata,
      .rsp_take(take), .rsp_full(rsp_full),
      .rsp_status(st), .rsp_sel(sel), .rsp_id(oid), .rsp_prio(opr), .rsp_added(added)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (cmd.rsp_load) vld_ff <= 1'b1;
      else if (take) vld_ff <= 1'b0;
   end

   // Capture the finished result so the datapath is free for the next item.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) out_ff <= {st, sel, oid, opr, added};
   end

   assign rsp.valid = vld_ff;
   assign rsp.data = out_ff;

   // A result never appears without one being loaded.
   a_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.rsp_load)) else $error("spurious result");
   // Nothing is accepted while a request is being worked on.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !req.ready) else $error("overlap");
endmodule

// File: design/lld_ctrl.sv
// Controller state machine of the dispatcher.
// Depends on lld_pkg.
module lld_ctrl import lld_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic rsp_full,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start_scan = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.is_service && !sts.empty_or_bad) state_in = S_SHIFT;
            else begin
               if (!sts.is_service) cmd.enq_commit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (sts.shift_last) begin
               cmd.srv_finish = 1'b1;
               state_in = S_DONE;
            end else cmd.shift_step = 1'b1;
         end
         S_DONE: begin
            if (!rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// File: design/lld_dpath.sv
// Datapath: queue memory, fill counters, scans and result register.
// Depends on lld_pkg.
module lld_dpath import lld_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic in_func,
   input  logic [15:0] in_id,
   input  logic [7:0] in_prio,
   input  logic [2:0] in_idx,
   input  logic csr_we,
   input  logic csr_addr,
   input  logic [7:0] csr_wdata,
   input  logic rsp_take,
   output logic rsp_full,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_sel,
   output logic [15:0] rsp_id,
   output logic [7:0] rsp_prio,
   output logic rsp_added
);
   entry_type mem [MaxServers*QueueDepth];
   logic [FillW-1:0] fill_ff [MaxServers];
   logic [2:0] init_ff;
   logic [7:0] thr_ff;
   logic [ActW-1:0] act_ff;
   logic [15:0] stamp_ff;

   logic func_ff;
   logic [15:0] id_ff;
   logic [7:0] prio_ff;
   logic [2:0] idx_ff;
   logic [SrvW:0] idx_ext;
   logic [SrvW-1:0] srv;

   logic [FillW-1:0] cnt_ff;       // scan counter: server or entry position
   logic [SrvW-1:0] best_ff;
   logic [FillW:0] best_load_ff;   // extra bit: "none yet"
   logic [SrvW+FillW-1:0] total_ff;
   logic [7:0] pick_prio_ff;
   entry_type pick_ent_ff;
   logic [PosW-1:0] sh_ff;
   entry_type rd_ff;
   logic rd_ok_ff;

   logic [1:0] st_ff;
   logic [2:0] sel_ff;
   logic [15:0] oid_ff;
   logic [7:0] opr_ff;
   logic add_ff, full_ff;

   logic [ActW-1:0] eff_init, act_lim;
   logic [FillW-1:0] n_srv;

   assign eff_init = (csr_wdata[2:0] == 3'd0) ? ActW'(1)
                   : (ActW'(csr_wdata[2:0]) > ActW'(MaxServers)) ? ActW'(MaxServers)
                   : ActW'(csr_wdata[2:0]);
   assign act_lim = (act_ff > ActW'(MaxServers)) ? ActW'(MaxServers) : act_ff;
   assign idx_ext = {1'b0, idx_ff} ;
   assign srv = idx_ff[SrvW-1:0];
   assign n_srv = fill_ff[srv];

   // read address: during service scan, entry cnt; during shift, sh+1
   logic [AddrW-1:0] raddr;
   assign raddr = cmd.shift_step ? {srv, PosW'(sh_ff + PosW'(1))}
                                 : {srv, cnt_ff[PosW-1:0]};

   assign sts.is_service = func_ff;
   assign sts.empty_or_bad = (idx_ext >= (SrvW+1)'(MaxServers)) || (n_srv == '0);
   // enqueue scan visits act_lim servers and then a drain step; service scan
   // compares each entry as it comes out of the registered memory read
   assign sts.scan_last = func_ff ? (sts.empty_or_bad || cnt_ff == n_srv)
                                  : (cnt_ff == FillW'(act_lim));
   assign sts.shift_last = (FillW'(sh_ff) + FillW'(1) >= n_srv);

   // enqueue decision terms
   logic [FillW:0] new_load;
   logic [SrvW+FillW+4:0] tot10, thr_act;
   logic grow;
   assign new_load = best_load_ff + (FillW+1)'(1);
   assign tot10 = ((SrvW+FillW+5)'(total_ff) + (SrvW+FillW+5)'(1))
                * (SrvW+FillW+5)'(10);
   assign thr_act = (SrvW+FillW+5)'(thr_ff) * (SrvW+FillW+5)'(act_lim);
   assign grow = (act_ff == {1'b0, init_ff == 3'd0 ? 3'd1 : init_ff})
               && (act_lim < ActW'(MaxServers))
               && ((SrvW+FillW+5)'(new_load) * (SrvW+FillW+5)'(10)
                   > (SrvW+FillW+5)'(thr_ff))
               && (tot10 > thr_act);
   logic enq_full;
   assign enq_full = best_load_ff >= (FillW+1)'(QueueDepth);

   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         func_ff <= in_func; id_ff <= in_id; prio_ff <= in_prio; idx_ff <= in_idx;
         cnt_ff <= '0; best_ff <= '0; best_load_ff <= '1; total_ff <= '0;
         rd_ok_ff <= 1'b0; sh_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (!func_ff) begin
            if (cnt_ff < FillW'(act_lim)) begin
               if ((FillW+1)'(fill_ff[cnt_ff[SrvW-1:0]]) < best_load_ff) begin
                  best_load_ff <= (FillW+1)'(fill_ff[cnt_ff[SrvW-1:0]]);
                  best_ff <= cnt_ff[SrvW-1:0];
               end
               total_ff <= total_ff + (SrvW+FillW)'(fill_ff[cnt_ff[SrvW-1:0]]);
            end
         end else begin
            rd_ok_ff <= cnt_ff < n_srv;
            if (rd_ok_ff) begin
               if (cnt_ff == FillW'(1) || rd_ff.prio < pick_prio_ff) begin
                  pick_prio_ff <= rd_ff.prio;
                  pick_ent_ff <= rd_ff;
                  sh_ff <= PosW'(cnt_ff - FillW'(1));
               end
            end
         end
         cnt_ff <= cnt_ff + FillW'(1);
      end
      if (cmd.shift_step) sh_ff <= sh_ff + PosW'(1);
   end

   // memory: one read, one write port
   logic we;
   logic [AddrW-1:0] waddr;
   entry_type wdata;
   logic shift_wr_ff;
   logic [AddrW-1:0] shift_waddr_ff;
   assign we = (cmd.enq_commit && !enq_full) || shift_wr_ff;
   assign waddr = shift_wr_ff ? shift_waddr_ff : {best_ff, best_load_ff[PosW-1:0]};
   assign wdata = shift_wr_ff ? rd_ff
                              : entry_type'{id: id_ff, prio: prio_ff, stamp: stamp_ff};

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (we) mem[waddr] <= wdata;
      shift_waddr_ff <= {srv, sh_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) shift_wr_ff <= 1'b0;
      else shift_wr_ff <= cmd.shift_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxServers; i++) fill_ff[i] <= '0;
         init_ff <= 3'd5; thr_ff <= 8'd32; act_ff <= ActW'(5); stamp_ff <= '0;
         full_ff <= 1'b0; add_ff <= 1'b0; st_ff <= ST_ENQ;
      end else begin
         if (csr_we && csr_addr == CSR_INITIAL) begin
            init_ff <= csr_wdata[2:0]; act_ff <= eff_init;
         end
         if (csr_we && csr_addr == CSR_THRESH) thr_ff <= csr_wdata;
         if (cmd.enq_commit) begin
            sel_ff <= 3'(best_ff);
            oid_ff <= '0; opr_ff <= '0;
            if (enq_full) begin
               st_ff <= ST_FULL; add_ff <= 1'b0;
            end else begin
               st_ff <= ST_ENQ;
               fill_ff[best_ff] <= FillW'(new_load);
               stamp_ff <= stamp_ff + 16'd1;
               add_ff <= grow;
               if (grow) act_ff <= act_lim + ActW'(1);
            end
         end
         if (func_ff && cmd.scan_step && sts.scan_last) begin
            sel_ff <= idx_ff; add_ff <= 1'b0;
            st_ff <= ST_NONE; oid_ff <= '0; opr_ff <= '0;
         end
         if (cmd.srv_finish) begin
            fill_ff[srv] <= n_srv - FillW'(1);
            st_ff <= ST_SERVED;
            oid_ff <= pick_ent_ff.id; opr_ff <= pick_ent_ff.prio;
         end
         if (cmd.rsp_load) full_ff <= 1'b1;
         else if (rsp_take) full_ff <= 1'b0;
      end
   end

   assign rsp_full = full_ff && !rsp_take;
   assign rsp_status = st_ff;
   assign rsp_sel = sel_ff;
   assign rsp_id = oid_ff;
   assign rsp_prio = opr_ff;
   assign rsp_added = add_ff;
endmodule

// File: tb/least_loaded_priority_dispatcher_top_test.sv
// Self-checking testbench for the least-loaded priority dispatcher.
// Depends on lld_pkg, lld_if and least_loaded_priority_dispatcher_top.
module least_loaded_priority_dispatcher_top_test;
   import lld_pkg::*;

   // Transaction layouts on the two channels, most significant field first
   typedef struct packed {
      logic        func;
      logic [15:0] task_id;
      logic [7:0]  prio;
      logic [2:0]  srv_idx;
   } dispatch_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  srv_sel;
      logic [15:0] task_id;
      logic [7:0]  prio;
      logic        added;
   } dispatch_rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
   } queued_task_type;

   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_addr = CSR_INITIAL;
   logic [7:0] csr_wdata = '0;

   lld_if #(.W($bits(dispatch_req_type))) req ();
   lld_if #(.W($bits(dispatch_rsp_type))) rsp ();

   least_loaded_priority_dispatcher_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Mirror of the dispatcher state
   queued_task_type server_q[MaxServers][$];
   int unsigned cfg_initial = 5;
   int unsigned cfg_thresh = 32;
   int unsigned active_servers = 5;

   dispatch_rsp_type pending_rsp[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit stall_free = 1'b0;
   int unsigned enq_pct = 50;

   always #1 clock = ~clock;

   function automatic int unsigned clamp_initial(int unsigned n);
      if (n < 1) return 1;
      if (n > MaxServers) return MaxServers;
      return n;
   endfunction

   // Work out the single result of one transaction and advance the mirror
   function automatic dispatch_rsp_type dispatch_outcome(dispatch_req_type r);
      dispatch_rsp_type o;
      int unsigned best, best_load, total, pick;
      o = '0;
      if (!r.func) begin
         best = 0;
         best_load = 32'hFFFF_FFFF;
         total = 0;
         for (int s = 0; s < active_servers; s++)
            if (server_q[s].size() < best_load) begin
               best_load = server_q[s].size();
               best = s;
            end
         o.srv_sel = 3'(best);
         if (best_load >= QueueDepth) begin
            o.status = ST_FULL;
            return o;
         end
         server_q[best].insert(server_q[best].size(),
                               queued_task_type'{id: r.task_id, prio: r.prio});
         o.status = ST_ENQ;
         for (int s = 0; s < active_servers; s++) total += server_q[s].size();
         if (active_servers == clamp_initial(cfg_initial) && active_servers < MaxServers
             && (best_load + 1) * 10 > cfg_thresh
             && total * 10 > cfg_thresh * active_servers) begin
            active_servers++;
            o.added = 1'b1;
         end
      end else begin
         o.srv_sel = r.srv_idx;
         if (server_q[r.srv_idx].size() == 0) begin
            o.status = ST_NONE;
            return o;
         end
         // smallest priority number, oldest first among equals
         pick = 0;
         for (int i = 1; i < server_q[r.srv_idx].size(); i++)
            if (server_q[r.srv_idx][i].prio < server_q[r.srv_idx][pick].prio) pick = i;
         o.status = ST_SERVED;
         o.task_id = server_q[r.srv_idx][pick].id;
         o.prio = server_q[r.srv_idx][pick].prio;
         server_q[r.srv_idx].delete(pick);
      end
      return o;
   endfunction

   // Offer one transaction; valid stays high after acceptance so that
   // back-to-back items never lower and raise it in the same step
   task automatic send_item(dispatch_req_type r);
      dispatch_rsp_type exp_rsp;
      if (!stall_free && $urandom_range(99) < 21) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 21);
      end
      req.valid <= 1'b1;
      req.data <= r;
      do @(posedge clock); while (!req.ready);
      exp_rsp = dispatch_outcome(r);
      pending_rsp.insert(pending_rsp.size(), exp_rsp);
   endtask

   task automatic send_enqueue(logic [15:0] id, logic [7:0] prio);
      send_item('{func: 1'b0, task_id: id, prio: prio, srv_idx: 3'($urandom)});
   endtask

   task automatic send_service(logic [2:0] idx);
      send_item('{func: 1'b1, task_id: 16'($urandom), prio: 8'($urandom), srv_idx: idx});
   endtask

   // Drop valid, let every result arrive, then allow the block to settle
   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic addr, logic [7:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_INITIAL) begin
         cfg_initial = value[2:0];
         active_servers = clamp_initial(cfg_initial);
      end else begin
         cfg_thresh = value;
      end
      @(posedge clock);
   endtask

   // Random receiver stall, switched off during the stall-free stretch
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= stall_free || ($urandom_range(99) >= 21);
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      dispatch_rsp_type got, exp;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.data;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
               error_count++;
            end
            if (got.srv_sel !== exp.srv_sel) begin
               $display("%0t: server_sel expected %0d actual %0d", $time, exp.srv_sel,
                        got.srv_sel);
               error_count++;
            end
            if (got.task_id !== exp.task_id) begin
               $display("%0t: task_id expected %h actual %h", $time, exp.task_id, got.task_id);
               error_count++;
            end
            if (got.prio !== exp.prio) begin
               $display("%0t: priority expected %h actual %h", $time, exp.prio, got.prio);
               error_count++;
            end
            if (got.added !== exp.added) begin
               $display("%0t: server_added expected %0d actual %0d", $time, exp.added,
                        got.added);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("least_loaded_priority_dispatcher_top_test: done, errors");
         $finish;
      end
   end

   // Extreme ids and priorities; the equal priorities land on different servers
   task automatic test_enqueue_extremes;
      send_enqueue(16'h0000, 8'h00);
      send_enqueue(16'hFFFF, 8'hFF);
      send_enqueue(16'hA5A5, 8'h80);
      send_enqueue(16'h5A5A, 8'h80);
      send_enqueue(16'h1234, 8'h7F);
      send_enqueue(16'h4321, 8'h7F);
      send_enqueue(16'hBEEF, 8'h01);
      for (int s = 0; s < MaxServers; s++) send_service(3'(s));
      drain();
   endtask

   // Empty queues and servicing an inactive server that still holds leftovers
   task automatic test_service_cases;
      send_service(3'd7);
      send_service(3'd0);
      drain();
      write_csr(CSR_INITIAL, 8'd7);
      write_csr(CSR_THRESH, 8'd255);
      for (int i = 0; i < 7; i++) send_enqueue(16'(i + 16'h0700), 8'(7 - i));
      drain();
      write_csr(CSR_INITIAL, 8'd2);
      send_service(3'd6);
      send_service(3'd6);
      drain();
   endtask

   // One active server filled past capacity, then emptied
   task automatic test_queue_full;
      write_csr(CSR_INITIAL, 8'd0);
      for (int i = 0; i < QueueDepth + 2; i++) send_enqueue(16'($urandom), 8'($urandom));
      for (int i = 0; i < QueueDepth + 1; i++) send_service(3'd0);
      drain();
   endtask

   // Threshold zero adds a server on the first enqueue; only once
   task automatic test_server_added;
      write_csr(CSR_INITIAL, 8'd7);
      write_csr(CSR_THRESH, 8'd0);
      for (int i = 0; i < 10; i++) send_enqueue(16'($urandom), 8'($urandom));
      for (int s = 0; s < MaxServers; s++) send_service(3'(s));
      drain();
   endtask

   // Random traffic under one setting; bias the mix to fill or drain queues
   task automatic test_random_traffic(int unsigned initial_n, int unsigned thresh,
                                      int unsigned n_items);
      write_csr(CSR_INITIAL, 8'(initial_n));
      write_csr(CSR_THRESH, 8'(thresh));
      for (int i = 0; i < n_items; i++) begin
         if (i % 60 == 0) enq_pct = $urandom_range(30, 80);
         if ($urandom_range(99) < enq_pct) begin
            if ($urandom_range(3) == 0)
               send_enqueue(16'($urandom), 8'($urandom_range(3)));
            else
               send_enqueue(16'($urandom), 8'($urandom));
         end else begin
            send_service(3'($urandom));
         end
      end
      drain();
   endtask

   initial begin
      req.valid <= 1'b0;
      req.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_enqueue_extremes();
      test_service_cases();
      test_queue_full();
      test_server_added();
      // run both sides without stalls for one whole phase
      stall_free = 1'b1;
      test_random_traffic(5, 32, 250);
      stall_free = 1'b0;
      test_random_traffic(7, 0, 250);
      test_random_traffic(1, 255, 200);
      test_random_traffic(2, 8, 200);
      test_random_traffic($urandom_range(7), $urandom_range(255), 200);
      if (error_count == 0)
         $display("least_loaded_priority_dispatcher_top_test: done, clean");
      else
         $display("least_loaded_priority_dispatcher_top_test: done, errors");
      $finish;
   end
endmodule
